[hw/rtl/dsalf_pkg.sv]
// shared types and constants for the signal aspect led fader
`timescale 1ns / 1ps
`default_nettype none

package dsalf_pkg;

    localparam int LAMP_COUNT = 5;
    localparam logic [6:0] FADE_STEPS = 7'd100;

    typedef logic [6:0] t_level;
    typedef logic [1:0] t_aspect;

    // request kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_PACKET  = 2'd1;
    localparam logic [1:0] KIND_ADVANCE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DECODER_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SIGNAL_MODE     = 2'd1;
    localparam logic [1:0] CFG_INVERT_OUTPUTS  = 2'd2;

    // accessory packet address byte has the form 10xxxxxx
    localparam logic [7:0] ACC_MASK  = 8'b1100_0000;
    localparam logic [7:0] ACC_MATCH = 8'b1000_0000;

    // aspects
    localparam t_aspect ASPECT_HP0    = 2'd0;
    localparam t_aspect ASPECT_HP1    = 2'd1;
    localparam t_aspect ASPECT_HP2    = 2'd2;
    localparam t_aspect ASPECT_HP0SH1 = 2'd3;

    // lamp levels per aspect, 0 on, 1 off; bit 0 green .. bit 4 white
    function automatic logic [LAMP_COUNT-1:0] aspect_levels(input t_aspect a);
        logic [LAMP_COUNT-1:0] lv;
        case (a)
            ASPECT_HP0:    lv = 5'b10101;
            ASPECT_HP1:    lv = 5'b11110;
            ASPECT_HP2:    lv = 5'b11010;
            ASPECT_HP0SH1: lv = 5'b01101;
            default:       lv = 5'b10101;
        endcase
        return lv;
    endfunction

    // last aspect of the advance cycle per signal mode
    function automatic t_aspect last_aspect(input logic [1:0] mode);
        t_aspect la;
        case (mode)
            2'd0:    la = ASPECT_HP1;
            2'd1:    la = ASPECT_HP2;
            2'd2:    la = ASPECT_HP0SH1;
            2'd3:    la = ASPECT_HP2;
            default: la = ASPECT_HP1;
        endcase
        return la;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dcc_signal_aspect_led_fader.sv]
// dcc accessory decoder driving a signal aspect with five lamp faders
// path: a taken request goes to the input register, then through the state update
// into the result register
// throughput: one request per cycle; o_in_stall rises only while a result waits
// reset (synchronous, active low): aspect hp0, all lamps on, faders at zero,
// config registers cleared, both pipeline slots empty
`timescale 1ns / 1ps
`default_nettype none

module dcc_signal_aspect_led_fader (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data,
    // request channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_dcc_address_byte,
    input  wire logic [7:0] i_dcc_data_byte,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_accepted,
    output logic [1:0]      o_aspect,
    output logic [6:0]      o_green_duty,
    output logic [6:0]      o_red_one_duty,
    output logic [6:0]      o_orange_duty,
    output logic [6:0]      o_red_two_duty,
    output logic [6:0]      o_white_duty
);

    localparam int LC = dsalf_pkg::LAMP_COUNT;

    // configuration registers
    logic [8:0] r_decoder_address;
    logic [1:0] r_signal_mode;
    logic       r_invert_outputs;

    // input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic [7:0] r_abyte;
    logic [7:0] r_dbyte;

    // block state
    dsalf_pkg::t_level  r_fade_level [LC];
    dsalf_pkg::t_level  n_fade_level [LC];
    logic [LC-1:0]      r_goal_high, n_goal_high;
    logic [LC-1:0]      r_shadow, n_shadow;
    dsalf_pkg::t_aspect r_aspect, n_aspect;

    // result register
    logic               r_out_valid;
    logic               r_accepted;
    logic               n_accepted;
    dsalf_pkg::t_aspect r_out_aspect;
    dsalf_pkg::t_level  r_out_level [LC];

    logic               fire;
    logic               in_take;
    logic               do_select;
    dsalf_pkg::t_aspect sel_aspect;
    logic [LC-1:0]      sel_levels;
    logic [8:0]         eff_address;
    logic               pkt_match;

    // the input slot moves on whenever the result slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // nine-bit address: inverted data bits 6..4 on top of address bits 5..0
    assign eff_address = {~r_dbyte[6:4], r_abyte[5:0]};
    assign pkt_match   = ((r_abyte & dsalf_pkg::ACC_MASK) == dsalf_pkg::ACC_MATCH)
                      && (eff_address == r_decoder_address)
                      && r_dbyte[3];

    // decide whether this request selects an aspect, and which
    always_comb begin
        do_select  = 1'b0;
        sel_aspect = r_aspect;
        n_accepted = 1'b0;
        case (r_kind)
            dsalf_pkg::KIND_PACKET: begin
                n_accepted = pkt_match;
                // port zero picks hp0/hp1, port one hp2/hp0sh1, others only ack
                if (pkt_match && (r_dbyte[2:1] == 2'd0)) begin
                    do_select  = 1'b1;
                    sel_aspect = {1'b0, r_dbyte[0]};
                end else if (pkt_match && (r_dbyte[2:1] == 2'd1)) begin
                    do_select  = 1'b1;
                    sel_aspect = {1'b1, r_dbyte[0]};
                end
            end
            dsalf_pkg::KIND_ADVANCE: begin
                do_select = 1'b1;
                // wrap also when a mode change left the aspect past the last one
                if (r_aspect >= dsalf_pkg::last_aspect(r_signal_mode)) begin
                    sel_aspect = dsalf_pkg::ASPECT_HP0;
                end else begin
                    sel_aspect = r_aspect + 2'd1;
                end
            end
            default: begin
                do_select = 1'b0;
            end
        endcase
    end

    assign sel_levels = dsalf_pkg::aspect_levels(sel_aspect);

    // per-lamp next state, all five lamps in parallel
    always_comb begin
        n_aspect    = do_select ? sel_aspect : r_aspect;
        n_goal_high = r_goal_high;
        n_shadow    = r_shadow;
        for (int i = 0; i < LC; i++) begin
            n_fade_level[i] = r_fade_level[i];
            if (r_kind == dsalf_pkg::KIND_TICK) begin
                // one step toward the goal end
                if (r_goal_high[i] && (r_fade_level[i] < dsalf_pkg::FADE_STEPS)) begin
                    n_fade_level[i] = r_fade_level[i] + 7'd1;
                end else if (r_goal_high[i] && (r_fade_level[i] > dsalf_pkg::FADE_STEPS)) begin
                    n_fade_level[i] = r_fade_level[i] - 7'd1;
                end else if (!r_goal_high[i] && (r_fade_level[i] != 7'd0)) begin
                    n_fade_level[i] = r_fade_level[i] - 7'd1;
                end
            end else if (do_select && (sel_levels[i] != r_shadow[i])) begin
                // lamp changes: restart its fade from the opposite end
                n_goal_high[i]  = sel_levels[i] ^ r_invert_outputs;
                n_fade_level[i] = (sel_levels[i] ^ r_invert_outputs) ? 7'd0
                                                                     : dsalf_pkg::FADE_STEPS;
                n_shadow[i]     = sel_levels[i];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decoder_address <= 9'd0;
            r_signal_mode     <= 2'd0;
            r_invert_outputs  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dsalf_pkg::CFG_DECODER_ADDRESS: r_decoder_address <= i_cfg_data;
                dsalf_pkg::CFG_SIGNAL_MODE:     r_signal_mode     <= i_cfg_data[1:0];
                dsalf_pkg::CFG_INVERT_OUTPUTS:  r_invert_outputs  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind  <= i_kind;
            r_abyte <= i_dcc_address_byte;
            r_dbyte <= i_dcc_data_byte;
        end
    end

    // block state, updated once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_high <= '0;
            r_shadow    <= '0;
            r_aspect    <= dsalf_pkg::ASPECT_HP0;
            for (int i = 0; i < LC; i++) begin
                r_fade_level[i] <= 7'd0;
            end
        end else if (fire) begin
            r_goal_high <= n_goal_high;
            r_shadow    <= n_shadow;
            r_aspect    <= n_aspect;
            for (int i = 0; i < LC; i++) begin
                r_fade_level[i] <= n_fade_level[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_accepted   <= n_accepted;
            r_out_aspect <= n_aspect;
            for (int i = 0; i < LC; i++) begin
                r_out_level[i] <= n_fade_level[i];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_aspect       = r_out_aspect;
    assign o_green_duty   = r_out_level[0];
    assign o_red_one_duty = r_out_level[1];
    assign o_orange_duty  = r_out_level[2];
    assign o_red_two_duty = r_out_level[3];
    assign o_white_duty   = r_out_level[4];

endmodule

`default_nettype wire
